### rtl/core/hglr_pkg.sv
// package of shared types and constants for the hex glyph line rasterizer
package hglr_pkg;

  localparam int unsigned GLYPH_HEIGHT = 16;
  localparam int unsigned MAX_DIGITS   = 64;

  localparam int unsigned ROW_W   = $clog2(GLYPH_HEIGHT);
  localparam int unsigned WORDS   = MAX_DIGITS / 4;
  localparam int unsigned WORD_W  = $clog2(WORDS);
  localparam int unsigned DCNT_W  = $clog2(MAX_DIGITS + 2);
  localparam int unsigned DIM_W   = 13;
  localparam int unsigned ADDR_W  = 24;
  localparam int unsigned CFG_W   = 13;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_WIDE_MODE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HEIGHT = 2'd2;

  localparam logic             WIDE_MODE_RST     = 1'b1;
  localparam logic [DIM_W-1:0] WINDOW_WIDTH_RST  = 13'd3840;
  localparam logic [DIM_W-1:0] WINDOW_HEIGHT_RST = 13'd2160;

  localparam logic [7:0] CHAR_COLON   = 8'h3A;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_NINE    = 8'h39;

  localparam logic [DCNT_W-1:0] DIGITS_WIDE   = DCNT_W'(MAX_DIGITS);
  localparam logic [DCNT_W-1:0] DIGITS_NARROW = DCNT_W'(MAX_DIGITS / 2);
  localparam logic [DCNT_W-1:0] DIGITS_SAT    = DCNT_W'(MAX_DIGITS + 1);

  typedef struct packed {
    logic [7:0] text_byte;
  } in_req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] row_address;
    logic [15:0]       row_bits;
    logic [15:0]       glyph_count;
    logic              last_row;
  } out_req_t;

  function automatic logic [3:0] decode_nibble(input logic [7:0] c);
    logic [3:0] n;
    if (c <= CHAR_NINE) begin
      n = c[3:0];
    end else begin
      n = c[3:0] + 4'd9;
    end
    return n;
  endfunction

endpackage

### rtl/core/hglr_stream_if.sv
// valid/ready stream interface carrying one request payload
interface hglr_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### rtl/core/hex_glyph_line_rasterizer.sv
// hex glyph line rasterizer: parses hex glyph text and emits framebuffer row masks
// sequence: a newline that completes a valid line starts a glyph in the base address state;
//   each row is then one nibble memory read, then the output register load, which
//   waits while the output is held; input bytes are taken again once the glyph is done
// throughput: one byte per cycle while scanning a line; the row loop sets the glyph rate
// reset: control, cursor and config registers clear to reset values; nibble memory is not cleared
module hex_glyph_line_rasterizer (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [hglr_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [hglr_pkg::CFG_W-1:0]        cfg_data_i,
  hglr_stream_if.sink                       req_i,
  hglr_stream_if.source                     res_o
);
  import hglr_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_READ = 3'd2;
  localparam logic [2:0] S_LOAD = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]        state_q, state_d;
  logic              wide_q;
  logic [DIM_W-1:0]  width_q, height_q;
  logic              colon_q;
  logic [DCNT_W-1:0] dcnt_q;
  logic [DIM_W-1:0]  cx_q, cy_q;
  logic [15:0]       total_q;
  logic              full_q;
  logic [ROW_W-1:0]  row_q;
  logic [ADDR_W-1:0] addr_q;
  logic              ovalid_q;
  out_req_t          out_q;

  logic [15:0]       mem [WORDS];
  logic [15:0]       rd_q;
  logic              rd_en;
  logic [WORD_W-1:0] rd_addr;
  logic              wr_en;
  logic [WORD_W-1:0] wr_word;
  logic [1:0]        wr_lane;
  logic [3:0]        wr_nib;

  logic              in_fire;
  logic [7:0]        c;
  logic              is_nl;
  logic              line_ok;
  logic [DCNT_W-1:0] need;
  logic              load_ok;
  logic [15:0]       bits;
  logic [DIM_W-1:0]  gw;
  logic [DIM_W-1:0]  cx_n, cy_n;
  logic              wrap_x, wrap_y;

  assign req_i.ready = (state_q == S_IDLE);
  assign in_fire     = req_i.valid && req_i.ready;
  assign c           = req_i.payload.text_byte;
  assign is_nl       = (c == CHAR_NEWLINE);
  assign need        = wide_q ? DIGITS_WIDE : DIGITS_NARROW;
  assign line_ok     = colon_q && (dcnt_q == need);

  // nibble store write
  assign wr_en   = in_fire && !full_q && !is_nl && colon_q && (dcnt_q < DIGITS_WIDE);
  assign wr_word = dcnt_q[WORD_W+1:2];
  assign wr_lane = ~dcnt_q[1:0];
  assign wr_nib  = decode_nibble(c);

  assign rd_en   = (state_q == S_READ);
  assign rd_addr = wide_q ? row_q : {1'b0, row_q[ROW_W-1:1]};

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_word][{wr_lane, 2'b00} +: 4] <= wr_nib;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_comb begin
    if (wide_q) begin
      bits = rd_q;
    end else if (row_q[0]) begin
      bits = {8'h00, rd_q[7:0]};
    end else begin
      bits = {8'h00, rd_q[15:8]};
    end
  end

  assign load_ok = !ovalid_q || res_o.ready;

  // cursor advance
  assign gw     = wide_q ? DIM_W'(16) : DIM_W'(8);
  assign cx_n   = cx_q + gw;
  assign wrap_x = ({1'b0, cx_n} + {1'b0, gw}) > {1'b0, width_q};
  assign cy_n   = cy_q + DIM_W'(GLYPH_HEIGHT);
  assign wrap_y = ({1'b0, cy_n} + (DIM_W + 1)'(GLYPH_HEIGHT)) > {1'b0, height_q};

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire && !full_q && is_nl && line_ok) begin
          state_d = S_MUL;
        end
      end
      S_MUL:  state_d = S_READ;
      S_READ: state_d = S_LOAD;
      S_LOAD: begin
        if (load_ok) begin
          state_d = (row_q == ROW_W'(GLYPH_HEIGHT - 1)) ? S_DONE : S_READ;
        end
      end
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      wide_q   <= WIDE_MODE_RST;
      width_q  <= WINDOW_WIDTH_RST;
      height_q <= WINDOW_HEIGHT_RST;
      colon_q  <= 1'b0;
      dcnt_q   <= '0;
      cx_q     <= '0;
      cy_q     <= '0;
      total_q  <= '0;
      full_q   <= 1'b0;
      row_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_WIDE_MODE:     wide_q   <= cfg_data_i[0];
          REG_WINDOW_WIDTH:  width_q  <= cfg_data_i[DIM_W-1:0];
          REG_WINDOW_HEIGHT: height_q <= cfg_data_i[DIM_W-1:0];
          default: ;
        endcase
      end
      if (in_fire && !full_q) begin
        if (is_nl) begin
          colon_q <= 1'b0;
          dcnt_q  <= '0;
          if (line_ok && total_q != 16'hFFFF) begin
            total_q <= total_q + 16'd1;
          end
        end else if (!colon_q) begin
          if (c == CHAR_COLON) begin
            colon_q <= 1'b1;
          end
        end else if (dcnt_q < DIGITS_SAT) begin
          dcnt_q <= dcnt_q + DCNT_W'(1);
        end
      end
      if (state_q == S_MUL) begin
        row_q <= '0;
      end
      if (state_q == S_LOAD && load_ok) begin
        ovalid_q <= 1'b1;
        row_q    <= row_q + ROW_W'(1);
      end else if (res_o.ready) begin
        ovalid_q <= 1'b0;
      end
      if (state_q == S_DONE) begin
        if (wrap_x) begin
          cx_q <= '0;
          cy_q <= cy_n;
          if (wrap_y) begin
            full_q <= 1'b1;
          end
        end else begin
          cx_q <= cx_n;
        end
      end
    end
  end

  // row address: base product once per glyph, then one stride per row
  always_ff @(posedge clk_i) begin
    if (state_q == S_MUL) begin
      addr_q <= ADDR_W'(width_q * cy_q) + ADDR_W'(cx_q);
    end else if (state_q == S_LOAD && load_ok) begin
      addr_q <= addr_q + ADDR_W'(width_q);
    end
    if (state_q == S_LOAD && load_ok) begin
      out_q.row_address <= addr_q;
      out_q.row_bits    <= bits;
      out_q.glyph_count <= total_q;
      out_q.last_row    <= (row_q == ROW_W'(GLYPH_HEIGHT - 1));
    end
  end

  assign res_o.valid   = ovalid_q;
  assign res_o.payload = out_q;

  a_full_stays_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_q && state_q == S_IDLE |=> state_q == S_IDLE)
    else $error("glyph emitted after screen full");

  a_dcnt_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dcnt_q <= DIGITS_SAT)
    else $error("digit count beyond saturation");

  a_total_before_rows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_MUL |-> total_q != 16'd0)
    else $error("rows started without a counted glyph");

  a_no_input_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_MUL |=> !in_fire)
    else $error("byte accepted during row emission");

endmodule
